/* rtl/tlc_pkg.sv */
// shared types, constants and helpers of the two-level cache controller
package tlc_pkg;

    localparam int ADDR_W    = 32;
    localparam int STAMP_W   = 32;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam int L1_LINES_DEF = 256;
    localparam int L2_SETS_DEF  = 256;
    localparam int L2_WAYS_DEF  = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_L1_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK   = 2'd3;

    // configuration reset values
    localparam logic [4:0] RST_L1_SIZE = 5'd12;
    localparam logic [4:0] RST_L2_SIZE = 5'd15;
    localparam logic [1:0] RST_WAYS    = 2'd2;
    localparam logic [3:0] RST_BLOCK   = 4'd5;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic l1_miss;
        logic l2_miss;
        logic write_back;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic look;
        logic ord;
        logic owr;
        logic clr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_old;
        logic clr_last;
    } t_sts;

    function automatic int floor_log2(input int n);
        int r;
        r = 0;
        for (int i = 1; i < 31; i++) begin
            if ((1 << i) <= n) begin
                r = i;
            end
        end
        return r;
    endfunction

endpackage

/* rtl/two_level_cache_controller_top.sv */
// top level of the two-level write-back cache metadata controller
// Usage: after reset the L2 metadata store is cleared one set per cycle,
// with busy high until the last set is cleared; configuration writes are
// taken during that time. An access transaction is taken when start is
// high and busy is low. It first reads the L1 tag and the L2 row, then
// does the compare, LRU select and the metadata write; when a valid L1
// line is evicted on a miss, its dirty bit and stamp then go back to its
// L2 copy through a second read and write of the single-ported L2 row
// store. The result flags appear on o_rsp for exactly one cycle with
// o_done high, in the cycle after the last step; the receiver cannot
// stall, so o_done must be sampled every cycle. A new transaction may
// start in that same cycle.
module two_level_cache_controller_top #(
    parameter int L1_LINES = tlc_pkg::L1_LINES_DEF,
    parameter int L2_SETS  = tlc_pkg::L2_SETS_DEF,
    parameter int L2_WAYS  = tlc_pkg::L2_WAYS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // access transaction
    input  logic                          start,
    output logic                          busy,
    input  tlc_pkg::t_req                 i_req,
    // result transaction
    output tlc_pkg::t_rsp                 o_rsp,
    output logic                          o_done,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [tlc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tlc_pkg::CFG_W-1:0]     i_cfg_data
);
    import tlc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: clear sweep, accept, lookup, optional hand-back of the old line
    tlc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // metadata stores and update logic
    tlc_dp #(
        .L1_LINES (L1_LINES),
        .L2_SETS  (L2_SETS),
        .L2_WAYS  (L2_WAYS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_rsp      (o_rsp),
        .o_done     (o_done)
    );

endmodule

/* rtl/tlc_ctrl.sv */
// sequencing state machine of the two-level cache controller
module tlc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tlc_pkg::t_sts i_sts,
    output tlc_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import tlc_pkg::*;

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_LOOK = 5'b00100,
        S_ORD  = 5'b01000,
        S_OWR  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE: if (i_start) n_state = S_LOOK;
            S_LOOK: n_state = i_sts.need_old ? S_ORD : S_IDLE;
            S_ORD:  n_state = S_OWR;
            S_OWR:  n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    assign o_cmd.accept = (r_state == S_IDLE) && i_start;
    assign o_cmd.look   = (r_state == S_LOOK);
    assign o_cmd.ord    = (r_state == S_ORD);
    assign o_cmd.owr    = (r_state == S_OWR);
    assign o_cmd.clr    = (r_state == S_CLR);
    assign o_busy       = (r_state != S_IDLE);

endmodule

/* rtl/tlc_dp.sv */
// metadata stores, lookup, lru select and update datapath
module tlc_dp #(
    parameter int L1_LINES = tlc_pkg::L1_LINES_DEF,
    parameter int L2_SETS  = tlc_pkg::L2_SETS_DEF,
    parameter int L2_WAYS  = tlc_pkg::L2_WAYS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tlc_pkg::t_cmd                 i_cmd,
    output tlc_pkg::t_sts                 o_sts,
    input  tlc_pkg::t_req                 i_req,
    input  logic                          i_cfg_we,
    input  logic [tlc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tlc_pkg::CFG_W-1:0]     i_cfg_data,
    output tlc_pkg::t_rsp                 o_rsp,
    output logic                          o_done
);
    import tlc_pkg::*;

    localparam int L1_IW  = (L1_LINES > 1) ? $clog2(L1_LINES) : 1;
    localparam int L2_IW  = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
    localparam int WAY_W  = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
    localparam int L1_CAP = floor_log2(L1_LINES);
    localparam int L2_CAP = floor_log2(L2_SETS);
    localparam int OBA_W  = ADDR_W + L1_CAP;

    // configuration
    logic [4:0] r_l1_size_log, r_l2_size_log;
    logic [1:0] r_ways_log;
    logic [3:0] r_block_log;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_size_log <= RST_L1_SIZE;
            r_l2_size_log <= RST_L2_SIZE;
            r_ways_log    <= RST_WAYS;
            r_block_log   <= RST_BLOCK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_L1_SIZE: r_l1_size_log <= i_cfg_data;
                CFG_L2_SIZE: r_l2_size_log <= i_cfg_data;
                CFG_WAYS:    r_ways_log    <= i_cfg_data[1:0];
                CFG_BLOCK:   r_block_log   <= i_cfg_data[3:0];
            endcase
        end
    end

    // geometry
    logic [4:0]        raw1, raw2, k1, k2, pow_ways, nways;
    logic [5:0]        sub2;
    logic [ADDR_W-1:0] m1, m2;
    logic [OBA_W-1:0]  m2_o;

    always_comb begin
        raw1 = (r_l1_size_log > {1'b0, r_block_log}) ?
               5'(r_l1_size_log - {1'b0, r_block_log}) : '0;
        k1   = (raw1 < 5'(L1_CAP)) ? raw1 : 5'(L1_CAP);
        sub2 = {2'b0, r_block_log} + {4'b0, r_ways_log};
        raw2 = ({1'b0, r_l2_size_log} > sub2) ? 5'({1'b0, r_l2_size_log} - sub2) : '0;
        k2   = (raw2 < 5'(L2_CAP)) ? raw2 : 5'(L2_CAP);
        pow_ways = 5'd1 << r_ways_log;
        nways    = (pow_ways < 5'(L2_WAYS)) ? pow_ways : 5'(L2_WAYS);
        m1   = ~({ADDR_W{1'b1}} << k1);
        m2   = ~({ADDR_W{1'b1}} << k2);
        m2_o = ~({OBA_W{1'b1}} << k2);
    end

    // input side
    logic [ADDR_W-1:0] ba_in;
    logic [L1_IW-1:0]  idx_in;
    logic [L2_IW-1:0]  set_in;

    assign ba_in  = i_req.address >> r_block_log;
    assign idx_in = L1_IW'(ba_in & m1);
    assign set_in = L2_IW'(ba_in & m2);

    logic              r_wr;
    logic [ADDR_W-1:0] r_ba;
    logic [L1_IW-1:0]  r_idx;
    logic [L2_IW-1:0]  r_set;
    logic [STAMP_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_wr  <= i_req.command;
            r_ba  <= ba_in;
            r_idx <= idx_in;
            r_set <= set_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.accept) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // l1 store: tags, dirty bits and stamps in memory, valid bits in flops
    logic [ADDR_W-1:0]  l1_tag_mem   [L1_LINES];
    logic               l1_dty_mem   [L1_LINES];
    logic [STAMP_W-1:0] l1_stamp_mem [L1_LINES];
    logic [L1_LINES-1:0] r_l1_vld;
    logic [ADDR_W-1:0]  r_l1_tag_rd;
    logic               r_l1_dty_rd;
    logic [STAMP_W-1:0] r_l1_stamp_rd;

    // l2 store: one row per set holding every way
    logic [L2_WAYS-1:0][ADDR_W-1:0]  l2_tag_mem   [L2_SETS];
    logic [L2_WAYS-1:0][1:0]         l2_flag_mem  [L2_SETS];
    logic [L2_WAYS-1:0][STAMP_W-1:0] l2_stamp_mem [L2_SETS];
    logic [L2_WAYS-1:0][ADDR_W-1:0]  r_l2_tag_rd;
    logic [L2_WAYS-1:0][1:0]         r_l2_flag_rd;
    logic [L2_WAYS-1:0][STAMP_W-1:0] r_l2_stamp_rd;

    logic [L2_IW-1:0] r_old_set, rd_set, wa;
    assign rd_set = i_cmd.ord ? r_old_set : set_in;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_l1_tag_rd   <= l1_tag_mem[idx_in];
            r_l1_dty_rd   <= l1_dty_mem[idx_in];
            r_l1_stamp_rd <= l1_stamp_mem[idx_in];
        end
        if (i_cmd.accept || i_cmd.ord) begin
            r_l2_tag_rd   <= l2_tag_mem[rd_set];
            r_l2_flag_rd  <= l2_flag_mem[rd_set];
            r_l2_stamp_rd <= l2_stamp_mem[rd_set];
        end
    end

    // lookup of the current access
    logic              l1_v, l1_d, l1_hit, hit_found, n_l1_dty, lk_wb, need_old;
    logic [ADDR_W-1:0] tag1, tag2;
    logic [WAY_W-1:0]  hit_way, vic;
    logic [STAMP_W-1:0] vmin;
    logic [OBA_W-1:0]  old_ba;
    logic [L2_WAYS-1:0][ADDR_W-1:0]  lk_tag;
    logic [L2_WAYS-1:0][1:0]         lk_flag;
    logic [L2_WAYS-1:0][STAMP_W-1:0] lk_stamp;

    assign l1_v     = r_l1_vld[r_idx];
    assign l1_d     = r_l1_dty_rd;
    assign tag1     = r_ba >> k1;
    assign tag2     = r_ba >> k2;
    assign l1_hit   = l1_v && (r_l1_tag_rd == tag1);
    assign need_old = !l1_hit && l1_v;
    assign old_ba   = (OBA_W'(r_l1_tag_rd) << k1) | OBA_W'(r_idx);

    always_comb begin
        hit_found = 1'b0;
        hit_way   = '0;
        for (int w = 0; w < L2_WAYS; w++) begin
            if (!hit_found && (5'(w) < nways) && r_l2_flag_rd[w][0] &&
                (r_l2_tag_rd[w] == tag2)) begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
        end
    end

    // lru victim, ties to the lowest way
    always_comb begin
        vic  = '0;
        vmin = r_l2_stamp_rd[0];
        for (int w = 1; w < L2_WAYS; w++) begin
            if ((5'(w) < nways) && (r_l2_stamp_rd[w] < vmin)) begin
                vmin = r_l2_stamp_rd[w];
                vic  = WAY_W'(w);
            end
        end
    end

    always_comb begin
        lk_tag   = r_l2_tag_rd;
        lk_flag  = r_l2_flag_rd;
        lk_stamp = r_l2_stamp_rd;
        lk_wb    = 1'b0;
        if (hit_found) begin
            lk_stamp[hit_way] = r_cnt;
            if (!l1_hit && r_wr) begin
                lk_flag[hit_way][1] = 1'b1;
            end
        end else if (!l1_hit) begin
            lk_wb         = (r_l2_flag_rd[vic] == 2'b11);
            lk_tag[vic]   = tag2;
            lk_flag[vic]  = {r_wr, 1'b1};
            lk_stamp[vic] = r_cnt;
        end
    end

    always_comb begin
        if (l1_hit) begin
            n_l1_dty = l1_d | r_wr;
        end else if (hit_found) begin
            n_l1_dty = r_l2_flag_rd[hit_way][1] | r_wr;
        end else begin
            n_l1_dty = r_wr;
        end
    end

    // state of the evicted l1 line, handed back to its l2 copy
    logic [OBA_W-1:0]   r_old_tag;
    logic               r_old_dty;
    logic [STAMP_W-1:0] r_old_stamp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_old_set   <= L2_IW'(old_ba & m2_o);
            r_old_tag   <= old_ba >> k2;
            r_old_dty   <= l1_d;
            r_old_stamp <= r_l1_stamp_rd;
        end
    end

    logic             ow_found;
    logic [WAY_W-1:0] ow_way;
    logic [L2_WAYS-1:0][1:0]         ow_flag;
    logic [L2_WAYS-1:0][STAMP_W-1:0] ow_stamp;

    always_comb begin
        ow_found = 1'b0;
        ow_way   = '0;
        for (int w = 0; w < L2_WAYS; w++) begin
            if (!ow_found && (5'(w) < nways) && r_l2_flag_rd[w][0] &&
                (OBA_W'(r_l2_tag_rd[w]) == r_old_tag)) begin
                ow_found = 1'b1;
                ow_way   = WAY_W'(w);
            end
        end
        ow_flag  = r_l2_flag_rd;
        ow_stamp = r_l2_stamp_rd;
        if (ow_found) begin
            ow_flag[ow_way][1] = r_old_dty;
            ow_stamp[ow_way]   = r_old_stamp;
        end
    end

    // clearing sweep after reset
    logic [L2_IW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_sts.clr_last = (r_clr_addr == L2_IW'(L2_SETS - 1));
    assign o_sts.need_old = need_old;

    // l2 write port
    logic [L2_WAYS-1:0][ADDR_W-1:0]  w_tag;
    logic [L2_WAYS-1:0][1:0]         w_flag;
    logic [L2_WAYS-1:0][STAMP_W-1:0] w_stamp;

    always_comb begin
        priority if (i_cmd.clr) begin
            wa      = r_clr_addr;
            w_tag   = '0;
            w_flag  = '0;
            w_stamp = '0;
        end else if (i_cmd.look) begin
            wa      = r_set;
            w_tag   = lk_tag;
            w_flag  = lk_flag;
            w_stamp = lk_stamp;
        end else begin
            wa      = r_old_set;
            w_tag   = r_l2_tag_rd;
            w_flag  = ow_flag;
            w_stamp = ow_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr || i_cmd.look || i_cmd.owr) begin
            l2_tag_mem[wa]   <= w_tag;
            l2_flag_mem[wa]  <= w_flag;
            l2_stamp_mem[wa] <= w_stamp;
        end
        if (i_cmd.look) begin
            l1_tag_mem[r_idx]   <= tag1;
            l1_dty_mem[r_idx]   <= n_l1_dty;
            l1_stamp_mem[r_idx] <= r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_vld <= '0;
        end else if (i_cmd.look) begin
            r_l1_vld[r_idx] <= 1'b1;
        end
    end

    // result
    logic  r_done;
    t_rsp  r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (i_cmd.look && !need_old) || i_cmd.owr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_rsp.l1_miss    <= !l1_hit;
            r_rsp.l2_miss    <= !l1_hit && !hit_found;
            r_rsp.write_back <= lk_wb;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_cmd.look || i_cmd.owr))
        else $error("result strobe without a finished lookup");
    a_l2_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!o_rsp.l2_miss || o_rsp.l1_miss))
        else $error("l2 miss reported on an l1 hit");
    a_wb_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!o_rsp.write_back || o_rsp.l2_miss))
        else $error("write-back without an l2 refill");
    a_owr_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.owr |-> $past(i_cmd.ord))
        else $error("old line update without its row read");

endmodule

/* tb/sv/two_level_cache_controller_top_tb.sv */
// testbench of the two-level cache controller: directed and random accesses checked against a predictor
`timescale 1ns / 100ps

module two_level_cache_controller_top_tb;
    import tlc_pkg::*;

    localparam int N_L1      = L1_LINES_DEF;
    localparam int N_SETS    = L2_SETS_DEF;
    localparam int N_WAYS    = L2_WAYS_DEF;
    localparam int MAX_CYC   = 600000;
    localparam bit [1:0] F_VALID = 2'b01;
    localparam bit [1:0] F_DIRTY = 2'b10;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_req                 i_req;
    t_rsp                 o_rsp;
    logic                 o_done;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    two_level_cache_controller_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .o_done     (o_done),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock, 2 ns period
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // predictor copy of the geometry registers
    bit [4:0] geo_l1_log;
    bit [4:0] geo_l2_log;
    bit [1:0] geo_ways_log;
    bit [3:0] geo_blk_log;

    // predictor copy of the metadata; tags kept 64 bits wide since a hand-back
    // under a changed geometry can rebuild a block address above 32 bits
    bit [63:0] l1_tag [N_L1];
    bit [1:0]  l1_flg [N_L1];
    bit [31:0] l1_stp [N_L1];
    bit [63:0] l2_tag [N_SETS*N_WAYS];
    bit [1:0]  l2_flg [N_SETS*N_WAYS];
    bit [31:0] l2_stp [N_SETS*N_WAYS];
    bit [31:0] access_cnt;

    t_rsp      flags_due [$];
    int        mismatches;
    bit        failed;
    int        cycle_cnt;
    int        idle_pct;
    bit [31:0] region [8];

    // index widths, capped at what the arrays hold
    function automatic int l1_index_bits();
        int raw;
        raw = (geo_l1_log > geo_blk_log) ? int'(geo_l1_log) - int'(geo_blk_log) : 0;
        return (raw < $clog2(N_L1)) ? raw : $clog2(N_L1);
    endfunction

    function automatic int l2_index_bits();
        int sub;
        int raw;
        sub = int'(geo_blk_log) + int'(geo_ways_log);
        raw = (int'(geo_l2_log) > sub) ? int'(geo_l2_log) - sub : 0;
        return (raw < $clog2(N_SETS)) ? raw : $clog2(N_SETS);
    endfunction

    function automatic int way_cnt();
        int w;
        w = 1 << geo_ways_log;
        return (w < N_WAYS) ? w : N_WAYS;
    endfunction

    // lowest valid way holding this block, or -1
    function automatic int l2_lookup(bit [63:0] blk);
        int        k2;
        bit [63:0] set;
        bit [63:0] tag;
        k2  = l2_index_bits();
        set = blk & ((64'd1 << k2) - 1);
        tag = blk >> k2;
        for (int w = 0; w < way_cnt(); w++) begin
            if (l2_flg[set*N_WAYS+w][0] && l2_tag[set*N_WAYS+w] == tag) begin
                return int'(set) * N_WAYS + w;
            end
        end
        return -1;
    endfunction

    // bring an L2 line into L1, handing the evicted line's state back first
    function automatic void move_to_l1(bit [63:0] blk, int pos);
        int        k1;
        int        idx;
        int        p;
        bit [63:0] old_blk;
        k1  = l1_index_bits();
        idx = int'(blk & ((64'd1 << k1) - 1));
        if (l1_flg[idx][0]) begin
            old_blk = (l1_tag[idx] << k1) | 64'(idx);
            p = l2_lookup(old_blk);
            if (p >= 0) begin
                l2_flg[p] = (l2_flg[p] & F_VALID) | (l1_flg[idx] & F_DIRTY);
                l2_stp[p] = l1_stp[idx];
            end
        end
        l1_tag[idx] = blk >> k1;
        l1_flg[idx] = l2_flg[pos];
        l1_stp[idx] = l2_stp[pos];
    endfunction

    // one access: update metadata, return the miss and write-back flags
    function automatic t_rsp predict_access(t_req rq);
        bit        wr;
        bit [63:0] blk;
        int        k1;
        int        k2;
        int        idx;
        int        p;
        int        base;
        int        victim;
        bit        hit1;
        bit        hit2;
        bit        wb;
        t_rsp      r;
        wr   = rq.command;
        blk  = 64'(rq.address) >> geo_blk_log;
        k1   = l1_index_bits();
        idx  = int'(blk & ((64'd1 << k1) - 1));
        hit2 = 1'b0;
        wb   = 1'b0;
        access_cnt++;
        hit1 = l1_flg[idx][0] && (l1_tag[idx] == (blk >> k1));
        if (hit1) begin
            if (wr) l1_flg[idx] |= F_DIRTY;
            l1_stp[idx] = access_cnt;
        end
        p = l2_lookup(blk);
        if (p >= 0) begin
            hit2 = 1'b1;
            l2_stp[p] = access_cnt;
            if (!hit1) begin
                if (wr) l2_flg[p] |= F_DIRTY;
                move_to_l1(blk, p);
            end
        end else if (!hit1) begin
            // refill the least recently stamped way, lowest way on a tie
            k2     = l2_index_bits();
            base   = int'(blk & ((64'd1 << k2) - 1)) * N_WAYS;
            victim = base;
            for (int w = 1; w < way_cnt(); w++) begin
                if (l2_stp[base+w] < l2_stp[victim]) victim = base + w;
            end
            wb = (l2_flg[victim] == (F_VALID | F_DIRTY));
            l2_tag[victim] = blk >> k2;
            l2_flg[victim] = F_VALID | (wr ? F_DIRTY : 2'b00);
            l2_stp[victim] = access_cnt;
            move_to_l1(blk, victim);
        end
        r.l1_miss    = !hit1;
        r.l2_miss    = !hit1 && !hit2;
        r.write_back = wb;
        return r;
    endfunction

    // result checker: every strobed result against the oldest expectation
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYC) begin
            $display("FAIL");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (flags_due.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %b", o_rsp);
            end else begin
                if (o_rsp !== flags_due[0]) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected l1 %b l2 %b wb %b, got l1 %b l2 %b wb %b",
                                 flags_due[0].l1_miss, flags_due[0].l2_miss,
                                 flags_due[0].write_back, o_rsp.l1_miss, o_rsp.l2_miss,
                                 o_rsp.write_back);
                    end
                end
                void'(flags_due.pop_front());
            end
        end
    end

    // one access transaction; start stays high when no gap follows
    task automatic send_access(bit cmd, bit [31:0] addr);
        t_req rq;
        rq.command = cmd;
        rq.address = addr;
        i_req <= rq;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        flags_due.push_back(predict_access(rq));
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // wait until every expected result has come back
    task automatic drain();
        start <= 1'b0;
        while (flags_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_L1_SIZE: geo_l1_log   = val;
            CFG_L2_SIZE: geo_l2_log   = val;
            CFG_WAYS:    geo_ways_log = val[1:0];
            CFG_BLOCK:   geo_blk_log  = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(bit [4:0] l1, bit [4:0] l2, bit [4:0] wl, bit [4:0] bl);
        drain();
        write_reg(CFG_L1_SIZE, l1);
        write_reg(CFG_L2_SIZE, l2);
        write_reg(CFG_WAYS, wl);
        write_reg(CFG_BLOCK, bl);
    endtask

    // addresses clustered around a few regions so lines get reused and evicted
    function automatic bit [31:0] pick_addr();
        if ($urandom_range(99) < 10) return $urandom;
        return region[$urandom_range(0, 7)] + ($urandom & 32'h0000_7fff);
    endfunction

    // reset geometry: hits, write hits, L1 eviction with hand-back, L2 write-back
    task automatic test_directed();
        idle_pct = 21;
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b0, 32'h0000_0004);
        send_access(1'b1, 32'h0000_0000);
        send_access(1'b1, 32'hffff_ffff);
        send_access(1'b0, 32'hffff_ffe0);
        // same L1 line, other tag: dirty line goes back to L2
        send_access(1'b0, 32'h0000_1000);
        send_access(1'b0, 32'h0000_0000);
        // six dirty lines into one 4-way L2 set force a dirty eviction
        for (int i = 0; i < 6; i++) send_access(1'b1, 32'(i) * 32'h0000_2000);
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b0, 32'h8000_0000);
        send_access(1'b1, 32'h7fff_ffff);
        drain();
    endtask

    // extremes of every register, including values past the documented range
    task automatic test_geometry_extremes();
        idle_pct = 21;
        set_geometry(5'd5, 5'd8, 5'd0, 5'd0);
        for (int i = 0; i < 40; i++) send_access(1'($urandom_range(0, 1)), $urandom & 32'h3ff);
        set_geometry(5'd16, 5'd19, 5'd3, 5'd8);
        for (int i = 0; i < 40; i++) send_access(1'($urandom_range(0, 1)), pick_addr());
        set_geometry(5'd31, 5'd31, 5'd31, 5'd31);
        for (int i = 0; i < 40; i++) send_access(1'($urandom_range(0, 1)), pick_addr());
        set_geometry(5'd0, 5'd0, 5'd1, 5'd4);
        for (int i = 0; i < 40; i++) send_access(1'($urandom_range(0, 1)), $urandom & 32'hfff);
        drain();
    endtask

    // random accesses, geometry reshuffled every hundred transactions
    task automatic test_random(int n, int pct);
        idle_pct = pct;
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0) begin
                for (int r = 0; r < 8; r++) region[r] = $urandom & 32'hfff0_0000;
                if ($urandom_range(3) == 0) begin
                    set_geometry(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom));
                end else begin
                    set_geometry(5'($urandom_range(5, 16)), 5'($urandom_range(8, 19)),
                                 5'($urandom_range(0, 3)), 5'($urandom_range(0, 8)));
                end
            end
            send_access(1'($urandom_range(0, 1)), pick_addr());
        end
        drain();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_L1_SIZE;
        i_cfg_data = '0;
        mismatches = 0;
        failed     = 1'b0;
        cycle_cnt  = 0;
        idle_pct   = 0;
        geo_l1_log   = RST_L1_SIZE;
        geo_l2_log   = RST_L2_SIZE;
        geo_ways_log = RST_WAYS;
        geo_blk_log  = RST_BLOCK;
        access_cnt   = '0;
        foreach (l1_tag[i]) begin
            l1_tag[i] = '0; l1_flg[i] = '0; l1_stp[i] = '0;
        end
        foreach (l2_tag[i]) begin
            l2_tag[i] = '0; l2_flg[i] = '0; l2_stp[i] = '0;
        end
        for (int r = 0; r < 8; r++) region[r] = 32'(r) << 20;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_geometry_extremes();
        test_random(450, 21);
        test_random(450, 53);
        test_random(450, 0);

        repeat (10) @(posedge i_clk);
        if (failed || flags_due.size() != 0) begin
            $display("FAIL");
        end else begin
            $display("PASS");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/tlc_pkg.sv
rtl/tlc_ctrl.sv
rtl/tlc_dp.sv
rtl/two_level_cache_controller_top.sv
tb/sv/two_level_cache_controller_top_tb.sv
